// ----- rtl/key_debounce_wheel_events_defines.svh -----
// Assertion macros for the key debounce and wheel event RTL.
// Depends on nothing; files that assert include it and provide clk and rst_n.
`ifndef KEY_DEBOUNCE_WHEEL_EVENTS_DEFINES_SVH
`define KEY_DEBOUNCE_WHEEL_EVENTS_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define KDW_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define KDW_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/kdw_pkg.sv -----
// Shared types and constants of the key debounce and wheel event block.
// Depends on nothing; both RTL modules of the block import it.
package kdw_pkg;

  // Sizing of the debouncer and the wheel step logic.
  localparam int NUM_KEYS    = 18;
  localparam int COUNT_WIDTH = 8;
  localparam int WHEEL_LIMIT = 5;

  // Fixed field widths of the channels.
  localparam int KEY_FIELD_W = 18;
  localparam int WHEEL_W     = 16;
  localparam int CONFIRM_W   = 8;
  localparam int CMP_W       = (COUNT_WIDTH > CONFIRM_W) ? COUNT_WIDTH : CONFIRM_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CONFIRM_COUNT = 1'b0,
    CFG_EVENT_ENABLE  = 1'b1
  } cfg_reg_e;

  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // One input request: raw key bits and the wheel movement of a frame.
  typedef struct packed {
    logic [KEY_FIELD_W-1:0]    key_bits;
    logic signed [WHEEL_W-1:0] wheel_delta;
  } in_t;

  // One result: debounced state, edges and gated events.
  typedef struct packed {
    logic [KEY_FIELD_W-1:0] pressed_state;
    logic [KEY_FIELD_W-1:0] press_edges;
    logic [KEY_FIELD_W-1:0] release_edges;
    logic [KEY_FIELD_W-1:0] press_events;
    logic                   wheel_up_event;
    logic                   wheel_down_event;
  } out_t;

  // Status of one key lane after the current frame.
  typedef struct packed {
    logic pressed;
    logic press_edge;
    logic release_edge;
  } lane_status_t;

endpackage

// ----- rtl/kdw_key_lane.sv -----
// Debounce lane for one key: up/down hold counter and pressed flag.
// Depends on kdw_pkg for the counter type and the lane status struct.
module kdw_key_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  held,
  input  kdw_pkg::count_t       confirm,
  output kdw_pkg::lane_status_t status
);
  import kdw_pkg::*;

  count_t             count_r, count_nxt;
  logic               pressed_r, pressed_nxt;
  logic [COUNT_WIDTH:0] count_inc;

  // Count up toward the confirm count while held, down toward zero while released.
  always_comb begin
    count_inc   = {1'b0, count_r} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    count_nxt   = count_r;
    pressed_nxt = pressed_r;
    status      = '0;
    if (held) begin
      if (count_inc >= {1'b0, confirm}) begin
        count_nxt   = confirm;
        pressed_nxt = 1'b1;
        status.press_edge = !pressed_r;
      end else begin
        count_nxt = count_inc[COUNT_WIDTH-1:0];
      end
    end else begin
      if (count_r == '0) begin
        pressed_nxt = 1'b0;
        status.release_edge = pressed_r;
      end else begin
        count_nxt = count_r - count_t'(1);
      end
    end
    status.pressed = pressed_nxt;
  end

  // Lane state advances only when a frame is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pressed_r <= 1'b0;
    end else if (en) begin
      count_r   <= count_nxt;
      pressed_r <= pressed_nxt;
    end
  end

endmodule

// ----- rtl/key_debounce_wheel_events.sv -----
// Top level of the key debouncer with wheel event generation.
// Depends on kdw_pkg, kdw_key_lane and key_debounce_wheel_events_defines.svh.
//
// Usage: each input request on in_data is one remote-control frame (raw key
// bits and a signed wheel delta). in_valid/in_stall and out_valid/out_stall
// form the two channels; a request moves when valid is high and stall is low.
// Configuration (confirm count, event enable) is written on cfg_valid/cfg_ready
// with cfg_addr selecting the register; cfg_ready is always high, and writes
// are expected only while the block is idle.
// Flow: a frame taken is registered in the input register, and its result is
// then registered on out_data in the result register, where out_valid rises.
// Throughput: one frame per cycle while not stalled. All key lanes and the wheel
// step update in parallel in a single stage between the input and result registers.
// When the receiver stalls, the result register holds; the input register still
// takes one more frame, after which in_stall follows out_stall.
// Reset (synchronous, rst_n low) clears all hold counters, pressed flags and
// the wheel accumulator, sets confirm count to 3 and disables events.
`include "key_debounce_wheel_events_defines.svh"

module key_debounce_wheel_events (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  kdw_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output kdw_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kdw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [kdw_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kdw_pkg::*;

  localparam logic signed [WHEEL_W-1:0] LIMIT_POS = WHEEL_W'(WHEEL_LIMIT);
  localparam logic signed [WHEEL_W-1:0] LIMIT_NEG = -WHEEL_W'(WHEEL_LIMIT);
  localparam logic signed [WHEEL_W:0]   SAT_MAX   = {2'b00, {(WHEEL_W-1){1'b1}}};
  localparam logic signed [WHEEL_W:0]   SAT_MIN   = {2'b11, {(WHEEL_W-1){1'b0}}};
  localparam logic [CMP_W-1:0]          COUNT_MAX_EXT = CMP_W'({COUNT_WIDTH{1'b1}});

  // Configuration registers.
  logic [CONFIRM_W-1:0] confirm_count_r, confirm_count_nxt;
  logic                 event_enable_r, event_enable_nxt;

  // Pipeline registers.
  logic                 s1_valid_r, s1_valid_nxt;
  in_t                  s1_data_r;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  // Wheel accumulator.
  logic signed [WHEEL_W-1:0] wheel_acc_r, wheel_acc_nxt;

  logic                 in_accept;
  logic                 advance;
  count_t               confirm;
  logic [CMP_W-1:0]     confirm_ext;
  logic [NUM_KEYS-1:0]  held;
  lane_status_t         lane_status [NUM_KEYS];
  logic [KEY_FIELD_W-1:0] state_vec, pedge_vec, redge_vec;
  logic signed [WHEEL_W:0]   wheel_sum;
  logic signed [WHEEL_W-1:0] wheel_sat;
  logic                 wheel_up, wheel_down;

  // Handshake: the stage advances when the result register is free or drained.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration register decode.
  always_comb begin
    confirm_count_nxt = confirm_count_r;
    event_enable_nxt  = event_enable_r;
    if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_addr))
        CFG_CONFIRM_COUNT: confirm_count_nxt = cfg_data[CONFIRM_W-1:0];
        CFG_EVENT_ENABLE:  event_enable_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate the confirm count to the counter range.
  always_comb begin
    confirm_ext = CMP_W'(confirm_count_r);
    if (confirm_ext > COUNT_MAX_EXT) begin
      confirm = '1;
    end else begin
      confirm = confirm_ext[COUNT_WIDTH-1:0];
    end
  end

  // One debounce lane per key; keys past the field width see a released bit.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < KEY_FIELD_W) begin : g_held
      assign held[k] = s1_data_r.key_bits[k];
    end else begin : g_idle
      assign held[k] = 1'b0;
    end
    kdw_key_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .held   (held[k]),
      .confirm(confirm),
      .status (lane_status[k])
    );
  end

  // Gather lane status into the result fields.
  for (genvar b = 0; b < KEY_FIELD_W; b++) begin : g_bit
    if (b < NUM_KEYS) begin : g_used
      assign state_vec[b] = lane_status[b].pressed;
      assign pedge_vec[b] = lane_status[b].press_edge;
      assign redge_vec[b] = lane_status[b].release_edge;
    end else begin : g_unused
      assign state_vec[b] = 1'b0;
      assign pedge_vec[b] = 1'b0;
      assign redge_vec[b] = 1'b0;
    end
  end

  // Wheel: saturating add, clamp to the limit, then one step toward zero.
  always_comb begin
    wheel_sum = {wheel_acc_r[WHEEL_W-1], wheel_acc_r}
              + {s1_data_r.wheel_delta[WHEEL_W-1], s1_data_r.wheel_delta};
    if (wheel_sum > SAT_MAX) begin
      wheel_sat = SAT_MAX[WHEEL_W-1:0];
    end else if (wheel_sum < SAT_MIN) begin
      wheel_sat = SAT_MIN[WHEEL_W-1:0];
    end else begin
      wheel_sat = wheel_sum[WHEEL_W-1:0];
    end
    wheel_up      = 1'b0;
    wheel_down    = 1'b0;
    wheel_acc_nxt = wheel_sat;
    if (wheel_sat > 0) begin
      wheel_up      = 1'b1;
      wheel_acc_nxt = ((wheel_sat > LIMIT_POS) ? LIMIT_POS : wheel_sat) - WHEEL_W'(1);
    end else if (wheel_sat < 0) begin
      wheel_down    = 1'b1;
      wheel_acc_nxt = ((wheel_sat < LIMIT_NEG) ? LIMIT_NEG : wheel_sat) + WHEEL_W'(1);
    end
  end

  // Result assembly with event gating.
  always_comb begin
    out_nxt                  = out_r;
    if (advance) begin
      out_nxt.pressed_state    = state_vec;
      out_nxt.press_edges      = pedge_vec;
      out_nxt.release_edges    = redge_vec;
      out_nxt.press_events     = event_enable_r ? pedge_vec : '0;
      out_nxt.wheel_up_event   = wheel_up && event_enable_r;
      out_nxt.wheel_down_event = wheel_down && event_enable_r;
    end
  end

  // Valid flags of the two stages.
  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_count_r <= CONFIRM_RESET;
      event_enable_r  <= 1'b0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      wheel_acc_r     <= '0;
    end else begin
      confirm_count_r <= confirm_count_nxt;
      event_enable_r  <= event_enable_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      if (advance) begin
        wheel_acc_r <= wheel_acc_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // A key cannot both press and release in the same frame.
  `KDW_ASSERT_NOW(a_edge_excl, out_valid_r, (out_r.press_edges & out_r.release_edges) == '0, "press and release edge on the same key")
  // Edges agree with the debounced state they produced.
  `KDW_ASSERT_NOW(a_edge_state, out_valid_r, ((out_r.press_edges & ~out_r.pressed_state) == '0) && ((out_r.release_edges & out_r.pressed_state) == '0), "edge disagrees with pressed state")
  // The wheel never steps both ways at once.
  `KDW_ASSERT_NOW(a_wheel_excl, out_valid_r, !(out_r.wheel_up_event && out_r.wheel_down_event), "wheel up and down in one frame")
  // Between frames the accumulator stays strictly inside the limit.
  `KDW_ASSERT_NOW(a_wheel_range, 1'b1, (wheel_acc_r < LIMIT_POS) && (wheel_acc_r > LIMIT_NEG), "wheel accumulator out of range")
  // A frame waiting behind a stalled result is not dropped.
  `KDW_ASSERT_NEXT(a_hold_frame, s1_valid_r && out_valid_r && out_stall, s1_valid_r, "waiting frame lost under stall")

endmodule
